// ----- rtl/core/pal_pkg.sv -----
// Shared types, constants and element conversions for the positional array list.
// Used by positional_array_list and the testbench; no dependencies.
`default_nettype none

package pal_pkg;

	// Storage geometry
	localparam int DEPTH  = 64;
	localparam int ELEM_W = 32;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);

	// Fixed field widths of the transactions
	localparam int PW     = 7;
	localparam int VW     = 32;

	// Width for position / count compares, with headroom for count + 1
	localparam int CMP_W  = ((CW > PW) ? CW : PW) + 1;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		op_t                  op;
		logic [PW-1:0]        position;
		logic signed [VW-1:0] value;
	} in_t;

	typedef struct packed {
		status_t              status;
		logic signed [VW-1:0] read_value;
		logic [PW-1:0]        count;
	} out_t;

	// Input word to stored element (truncate or sign-extend)
	function automatic logic [ELEM_W-1:0] to_elem(input logic signed [VW-1:0] v);
		return ELEM_W'(v);
	endfunction

	// Stored element to output word (sign-extend or truncate)
	function automatic logic signed [VW-1:0] from_elem(input logic signed [ELEM_W-1:0] e);
		return VW'(e);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pal_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none

module pal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/positional_array_list.sv -----
// Positional array list: ordered list of signed words kept in one dual-port RAM.
// Depends on pal_pkg and pal_ram.
//
// Usage:
//   in_data  (valid/ready): one operation per transaction: clear, insert at a
//            one-based position, delete at a position, or read at a position.
//   out_data (valid/ready): exactly one result per operation: status, read value
//            and the element count after the operation.
// Sequence from acceptance to result valid:
//   clear, any error, insert at the end, delete of the last entry: the result
//   is registered straight from idle. read: one RAM read, then the result (S_RD).
//   insert at position p: the entries from p to the end move up one slot, last
//   first (S_SHUP), then the new value is written into the opened slot (S_PUT).
//   delete at position p: the entries after p move down one slot (S_SHDN).
// One operation is in flight at a time; the next is accepted once the list is
// back in idle and the result register is empty or being taken. The shift moves
// one entry per cycle through the RAM (read entry i, write its neighbor).
// Reset empties the list; stored words are not cleared and are never read back
// before being written. A stalled receiver holds the result register and input
// acceptance stops until the result is taken.
`default_nettype none

module positional_array_list (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire pal_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output pal_pkg::out_t      out_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_SHUP,
		S_PUT,
		S_SHDN
	} state_t;

	state_t                          state_q, state_d;
	logic [pal_pkg::CW-1:0]          count_q, count_d;
	logic [pal_pkg::AW-1:0]          idx_q, idx_d;
	logic [pal_pkg::AW-1:0]          tgt_q, tgt_d;
	logic [pal_pkg::ELEM_W-1:0]      val_q, val_d;
	logic                            out_valid_q;
	pal_pkg::out_t                   out_q, res_d;
	logic                            res_ld;
	logic                            acc;

	logic [pal_pkg::CMP_W-1:0]       n_x, p_x, p_eff;
	logic                            is_empty, ins_full, ins_bad, ins_app, pos_bad, del_last;

	logic                            ram_we;
	logic [pal_pkg::AW-1:0]          ram_waddr, ram_raddr;
	logic [pal_pkg::ELEM_W-1:0]      ram_wdata, ram_rdata;

	pal_ram #(
		.WIDTH(pal_pkg::ELEM_W),
		.DEPTH(pal_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// position checks against the current count
	always_comb begin
		n_x      = pal_pkg::CMP_W'(count_q);
		p_x      = pal_pkg::CMP_W'(in_data.position);
		is_empty = (count_q == '0);
		p_eff    = is_empty ? pal_pkg::CMP_W'(1) : p_x;
		ins_full = (n_x >= pal_pkg::CMP_W'(pal_pkg::DEPTH));
		ins_bad  = (p_eff == '0) || (p_eff > n_x + pal_pkg::CMP_W'(1));
		ins_app  = (p_eff == n_x + pal_pkg::CMP_W'(1));
		pos_bad  = (p_x == '0) || (p_x > n_x);
		del_last = (p_x == n_x);
	end

	// next state, RAM control and result formation
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		tgt_d     = tgt_q;
		val_d     = val_q;
		res_ld    = 1'b0;
		res_d     = '{status: pal_pkg::ST_OK, read_value: '0,
			count: pal_pkg::PW'(count_q)};
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_raddr = pal_pkg::AW'(p_x - pal_pkg::CMP_W'(1));

		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (in_data.op)
						pal_pkg::OP_CLEAR: begin
							count_d      = '0;
							res_ld       = 1'b1;
							res_d.count  = '0;
						end
						pal_pkg::OP_INSERT: begin
							ram_raddr = pal_pkg::AW'(n_x - pal_pkg::CMP_W'(1));
							if (ins_full) begin
								res_ld       = 1'b1;
								res_d.status = pal_pkg::ST_FULL;
							end else if (ins_bad) begin
								res_ld       = 1'b1;
								res_d.status = pal_pkg::ST_BADPOS;
							end else if (ins_app) begin
								ram_we      = 1'b1;
								ram_waddr   = pal_pkg::AW'(n_x);
								ram_wdata   = pal_pkg::to_elem(in_data.value);
								count_d     = count_q + pal_pkg::CW'(1);
								res_ld      = 1'b1;
								res_d.count = pal_pkg::PW'(count_d);
							end else begin
								idx_d   = pal_pkg::AW'(n_x);
								tgt_d   = pal_pkg::AW'(p_eff - pal_pkg::CMP_W'(1));
								val_d   = pal_pkg::to_elem(in_data.value);
								state_d = S_SHUP;
							end
						end
						pal_pkg::OP_DELETE: begin
							ram_raddr = pal_pkg::AW'(p_x);
							if (is_empty) begin
								res_ld       = 1'b1;
								res_d.status = pal_pkg::ST_EMPTY;
							end else if (pos_bad) begin
								res_ld       = 1'b1;
								res_d.status = pal_pkg::ST_BADPOS;
							end else if (del_last) begin
								count_d     = count_q - pal_pkg::CW'(1);
								res_ld      = 1'b1;
								res_d.count = pal_pkg::PW'(count_d);
							end else begin
								idx_d   = pal_pkg::AW'(p_x - pal_pkg::CMP_W'(1));
								state_d = S_SHDN;
							end
						end
						pal_pkg::OP_READ: begin
							if (is_empty) begin
								res_ld       = 1'b1;
								res_d.status = pal_pkg::ST_EMPTY;
							end else if (pos_bad) begin
								res_ld       = 1'b1;
								res_d.status = pal_pkg::ST_BADPOS;
							end else begin
								state_d = S_RD;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_RD: begin
				res_ld           = 1'b1;
				res_d.read_value = pal_pkg::from_elem(ram_rdata);
				state_d          = S_IDLE;
			end
			// move entry idx-1 up into idx; fetch idx-2 for the next cycle
			S_SHUP: begin
				ram_we    = 1'b1;
				ram_raddr = idx_q - pal_pkg::AW'(2);
				idx_d     = idx_q - pal_pkg::AW'(1);
				if (idx_d == tgt_q) begin
					state_d = S_PUT;
				end
			end
			// drop the new value into the opened slot
			S_PUT: begin
				ram_we      = 1'b1;
				ram_waddr   = tgt_q;
				ram_wdata   = val_q;
				count_d     = count_q + pal_pkg::CW'(1);
				res_ld      = 1'b1;
				res_d.count = pal_pkg::PW'(count_d);
				state_d     = S_IDLE;
			end
			// move entry idx+1 down into idx; fetch idx+2 for the next cycle
			S_SHDN: begin
				ram_we    = 1'b1;
				ram_raddr = idx_q + pal_pkg::AW'(2);
				idx_d     = idx_q + pal_pkg::AW'(1);
				if (pal_pkg::CMP_W'(idx_q) + pal_pkg::CMP_W'(2) >= n_x) begin
					count_d     = count_q - pal_pkg::CW'(1);
					res_ld      = 1'b1;
					res_d.count = pal_pkg::PW'(count_d);
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		tgt_q <= tgt_d;
		val_q <= val_d;
		if (res_ld) begin
			out_q <= res_d;
		end
	end

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pal_pkg::CW'(pal_pkg::DEPTH))
		else $error("element count above capacity");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !out_valid_q)
		else $error("result pending while a shift is in progress");

	a_shift_up_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHUP) |-> (idx_q > tgt_q))
		else $error("insert shift passed its target slot");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_data.op == pal_pkg::OP_READ && !is_empty && !pos_bad) |=> out_valid_q == 1'b0
		##1 out_valid_q)
		else $error("read result not produced on time");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_positional_array_list.sv -----
// Self-checking testbench for positional_array_list: directed and random list operations,
// predicted by a scoreboard class and compared against every result transaction.
// Depends on pal_pkg and the positional_array_list RTL.
`timescale 1ns / 100ps

module tb_positional_array_list;
	import pal_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_OPS   = 1100;
	localparam int MAX_REPORTED = 10;

	// Scoreboard: shadow copy of the list, expected result queue, mismatch tally
	class list_scoreboard;
		logic [ELEM_W-1:0] slots [DEPTH];
		int unsigned       n_entries;
		int unsigned       peak_entries;
		out_t              want_q [$];
		int                errors;
		int                n_ops;
		int                status_tally [4];

		function new();
			n_entries = 0;
			peak_entries = 0;
			errors = 0;
			n_ops = 0;
			foreach (status_tally[i]) status_tally[i] = 0;
		endfunction

		// Apply one accepted operation to the shadow list and queue its result
		function void note_op(in_t t);
			out_t r;
			int   p;
			r.status = ST_OK;
			r.read_value = '0;
			p = int'(t.position);
			case (t.op)
				OP_CLEAR: begin
					n_entries = 0;
				end
				OP_INSERT: begin
					if (n_entries >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						// empty list: position is don't-care, value lands at the head
						if (n_entries == 0) p = 1;
						if (p < 1 || p > int'(n_entries) + 1) begin
							r.status = ST_BADPOS;
						end else begin
							for (int i = n_entries; i > p - 1; i--) slots[i] = slots[i - 1];
							slots[p - 1] = ELEM_W'(t.value);
							n_entries++;
						end
					end
				end
				OP_DELETE: begin
					if (n_entries == 0) begin
						r.status = ST_EMPTY;
					end else if (p < 1 || p > int'(n_entries)) begin
						r.status = ST_BADPOS;
					end else begin
						for (int i = p - 1; i + 1 < int'(n_entries); i++) slots[i] = slots[i + 1];
						n_entries--;
					end
				end
				default: begin
					if (n_entries == 0) begin
						r.status = ST_EMPTY;
					end else if (p < 1 || p > int'(n_entries)) begin
						r.status = ST_BADPOS;
					end else begin
						r.read_value = VW'($signed(slots[p - 1]));
					end
				end
			endcase
			r.count = PW'(n_entries);
			if (n_entries > peak_entries) peak_entries = n_entries;
			status_tally[int'(r.status)]++;
			n_ops++;
			want_q.push_back(r);
		endfunction

		// Compare one result transaction with the oldest expectation
		function void check_result(out_t got);
			out_t want;
			if (want_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTED)
					$display("ERROR: unexpected result status=%0d read_value=%0d count=%0d",
						got.status, got.read_value, got.count);
				return;
			end
			want = want_q.pop_front();
			if (got.status !== want.status || got.read_value !== want.read_value ||
					got.count !== want.count) begin
				errors++;
				if (errors <= MAX_REPORTED)
					$display("ERROR: result mismatch: expected status=%0d read_value=%0d count=%0d, got status=%0d read_value=%0d count=%0d",
						want.status, want.read_value, want.count,
						got.status, got.read_value, got.count);
			end
		endfunction

		function int pending();
			return want_q.size();
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	in_t   in_data = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	out_t  out_data;

	int    snd_idle = 12;
	int    rcv_idle = 87;
	int    cycles = 0;
	bit    growing = 1'b1;

	list_scoreboard sb = new();

	positional_array_list u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Cycle watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: random back-pressure, check each accepted result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	function automatic in_t mk_op(op_t o, int p, logic [VW-1:0] v);
		in_t t;
		t.op = o;
		t.position = PW'(p);
		t.value = v;
		return t;
	endfunction

	// Drive one transaction, idling beforehand at the sender's rate; returns at acceptance
	task automatic send_op(in_t t);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_op(t);
	endtask

	// Random operation: grow or shrink bias, mostly legal positions, some edges and noise
	function automatic in_t rand_op(int unsigned n, bit grow);
		int   r;
		int   lim;
		int   p;
		op_t  o;
		logic [VW-1:0] v;
		r = $urandom_range(99);
		if (grow)
			o = (r < 65) ? OP_INSERT : (r < 75) ? OP_DELETE : OP_READ;
		else
			o = (r < 3) ? OP_CLEAR : (r < 15) ? OP_INSERT : (r < 72) ? OP_DELETE : OP_READ;
		lim = (o == OP_INSERT) ? int'(n) + 1 : int'(n);
		r = $urandom_range(99);
		if (o == OP_CLEAR || r < 5 || lim == 0)
			p = $urandom_range(127);
		else if (r < 12)
			p = 0;
		else if (r < 19)
			p = lim + 1;
		else if (r < 29)
			p = 1;
		else if (r < 39)
			p = lim;
		else
			p = $urandom_range(lim, 1);
		r = $urandom_range(99);
		case (r)
			0, 1, 2: v = 32'h8000_0000;
			3, 4, 5: v = 32'h7FFF_FFFF;
			6, 7:    v = '1;
			8, 9:    v = '0;
			default: v = $urandom;
		endcase
		return mk_op(o, p, v);
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, position edges, insert front/middle/end, delete cases
		send_op(mk_op(OP_READ,   1,   32'd5));
		send_op(mk_op(OP_DELETE, 1,   32'd0));
		send_op(mk_op(OP_INSERT, 0,   32'h7FFF_FFFF));
		send_op(mk_op(OP_INSERT, 127, 32'h1234_5678));
		send_op(mk_op(OP_INSERT, 0,   32'h1234_5678));
		send_op(mk_op(OP_INSERT, 1,   32'h8000_0000));
		send_op(mk_op(OP_INSERT, 3,   32'hFFFF_FFFF));
		send_op(mk_op(OP_INSERT, 2,   32'h0000_0000));
		send_op(mk_op(OP_READ,   0,   32'd0));
		send_op(mk_op(OP_READ,   5,   32'd0));
		for (int i = 1; i <= 4; i++) send_op(mk_op(OP_READ, i, 32'd0));
		send_op(mk_op(OP_DELETE, 0,   32'd0));
		send_op(mk_op(OP_DELETE, 5,   32'd0));
		send_op(mk_op(OP_DELETE, 2,   32'd0));
		send_op(mk_op(OP_DELETE, 3,   32'd0));
		send_op(mk_op(OP_DELETE, 1,   32'd0));
		send_op(mk_op(OP_READ,   1,   32'd0));
		send_op(mk_op(OP_CLEAR,  0,   32'd0));
		send_op(mk_op(OP_READ,   1,   32'd0));
		send_op(mk_op(OP_INSERT, 127, 32'd1));

		// Random: three idle profiles, list swings between empty and full
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i == RANDOM_OPS / 3) begin
				snd_idle = 87;
				rcv_idle = 12;
			end else if (i == 2 * RANDOM_OPS / 3) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			if (sb.n_entries == DEPTH && $urandom_range(3) == 0) growing = 1'b0;
			if (sb.n_entries == 0 && $urandom_range(2) == 0) growing = 1'b1;
			send_op(rand_op(sb.n_entries, growing));
		end
		in_valid <= 1'b0;

		// Drain, then allow for a worst-case shift before closing
		while (sb.pending() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("Covered %0d list operations, peak occupancy %0d of %0d entries",
			sb.n_ops, sb.peak_entries, DEPTH);
		$display("Status mix: %0d ok, %0d bad position, %0d full, %0d empty; %0d mismatches",
			sb.status_tally[ST_OK], sb.status_tally[ST_BADPOS], sb.status_tally[ST_FULL],
			sb.status_tally[ST_EMPTY], sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/pal_pkg.sv
rtl/core/pal_ram.sv
rtl/core/positional_array_list.sv
tb/tb_positional_array_list.sv
